// ===== rtl/pffla_pkg.sv =====
package pffla_pkg;

    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 19;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 8;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLY,
        ST_ALLOC,
        ST_FREE
    } pffla_state_t;

endpackage

// ===== rtl/page_frame_free_list_allocator.sv =====
// Channel   Direction  tdata (low bit up)                    tuser / tlast
// s_axis    in         page_count[6:0], page_address[25:7]   tuser[0] kind
// m_axis    out        granted_address[18:0]                 tuser[1:0] status, tlast last
//
// Allocate of n pages: the transaction is taken, then one page is granted per cycle
// while m_axis is not stalled, set by the single read port of the link memory.
// Free, and any rejected request: taken, then answered from ST_FREE or ST_REPLY.
// Reset needs no clearing pass; a high-water mark stands in for the initial links.
// A stalled m_axis holds the sequencer; s_axis is taken only while idle.
module page_frame_free_list_allocator
    import pffla_pkg::*;
#(
    parameter int PAGES       = 128,
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_REQUEST = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // page_count[6:0], page_address[25:7]
    input  logic [0:0]            s_axis_tuser,   // kind[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // granted_address[18:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // status[1:0]
    output logic                  m_axis_tlast
);

    localparam int IDX_W      = $clog2(PAGES);
    localparam int LINK_W     = $clog2(PAGES + 1);
    localparam int WORD_W     = LINK_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] OFFS_MASK = ADDR_W'((1 << PAGE_SHIFT) - 1);

    pffla_state_t state_reg, state_next;

    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   count_reg, count_next;
    logic [LINK_W-1:0]   hw_reg, hw_next;
    logic [COUNT_W-1:0]  remain_reg, remain_next;
    logic [LINK_W-1:0]   frame_reg, frame_next;
    logic [STATUS_W-1:0] reply_reg, reply_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [COUNT_W-1:0]  in_count;
    logic [ADDR_W-1:0]   in_addr;
    logic [31:0]         in_frame;
    logic                alloc_bad;
    logic                free_bad;
    logic                slot_free;
    logic                head_fresh;
    logic [LINK_W-1:0]   eff_link;
    logic                frame_fresh;
    logic                frame_used;
    logic [31:0]         grant_wide;

    pffla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_count  = s_axis_tdata[COUNT_W-1:0];
    assign in_addr   = s_axis_tdata[COUNT_W+ADDR_W-1:COUNT_W];
    assign in_frame  = 32'(in_addr) >> PAGE_SHIFT;
    assign alloc_bad = (in_count == '0) || (32'(in_count) > MAX_REQUEST)
                       || (32'(in_count) > 32'(count_reg));
    assign free_bad  = ((in_addr & OFFS_MASK) != '0) || (in_frame >= PAGES);

    assign slot_free   = !out_valid_reg || m_axis_tready;
    assign head_fresh  = head_reg >= hw_reg;
    assign eff_link    = head_fresh ? head_reg + LINK_W'(1) : ram_rdata[LINK_W-1:0];
    assign frame_fresh = frame_reg >= hw_reg;
    assign frame_used  = !frame_fresh && ram_rdata[LINK_W];
    assign grant_wide  = 32'(head_reg) << PAGE_SHIFT;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        remain_next     = remain_reg;
        frame_next      = frame_reg;
        reply_next      = reply_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg[IDX_W-1:0];
        ram_wdata       = {1'b1, eff_link};
        ram_re          = 1'b0;
        ram_raddr       = head_reg[IDX_W-1:0];
        s_axis_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                remain_next   = in_count;
                frame_next    = LINK_W'(in_frame);
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0] == KIND_ALLOC)
                    begin
                        if (alloc_bad)
                        begin
                            reply_next = STATUS_NO_SPACE;
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_ALLOC;
                        end
                    end
                    else
                    begin
                        if (free_bad)
                        begin
                            reply_next = STATUS_NOT_HELD;
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = in_frame[IDX_W-1:0];
                            state_next = ST_FREE;
                        end
                    end
                end
            end
            ST_REPLY:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = reply_reg;
                    out_addr_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                if (slot_free)
                begin
                    ram_we          = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_addr_next   = grant_wide[ADDR_W-1:0];
                    out_last_next   = (remain_reg == COUNT_W'(1));
                    head_next       = eff_link;
                    count_next      = count_reg - LINK_W'(1);
                    remain_next     = remain_reg - COUNT_W'(1);
                    if (head_fresh)
                    begin
                        hw_next = head_reg + LINK_W'(1);
                    end
                    if (remain_reg == COUNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = eff_link[IDX_W-1:0];
                    end
                end
            end
            ST_FREE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                    if (frame_used)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = frame_reg[IDX_W-1:0];
                        ram_wdata       = {1'b0, head_reg};
                        head_next       = frame_reg;
                        count_next      = count_reg + LINK_W'(1);
                        out_status_next = STATUS_OK;
                    end
                    else
                    begin
                        out_status_next = STATUS_NOT_HELD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= LINK_W'(PAGES);
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg     <= remain_next;
        frame_reg      <= frame_next;
        reply_reg      <= reply_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_addr_reg);
    assign m_axis_tuser  = OUT_USER_W'(out_status_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/pffla_ram.sv =====
module pffla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/pffla_checker.sv =====
module pffla_checker
    import pffla_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    logic [STATUS_W-1:0] status;

    assign status = m_axis_tuser[STATUS_W-1:0];

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status != STATUS_OK |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("failure result not single or address not zero");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> status == STATUS_OK || status == STATUS_NO_SPACE
            || status == STATUS_NOT_HELD)
        else $error("unknown status code");

endmodule

bind page_frame_free_list_allocator pffla_checker u_pffla_checker (.*);

// ===== tb/page_frame_free_list_allocator_test.sv =====
module page_frame_free_list_allocator_test
    import pffla_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES       = 128;
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_REQUEST = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 23;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   address;
        logic                last;
    } grant_t;

    typedef struct packed {
        logic                kind;
        logic [COUNT_W-1:0]  count;
        logic [ADDR_W-1:0]   addr;
        logic                listed;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   base;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    logic [7:0]  link_mem [PAGES];
    logic [7:0]  head;
    int unsigned avail;
    logic        held [PAGES];

    grant_t pending_grants [$];
    int     mismatches = 0;
    int     cycle_count = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    bit     hold_request = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{KIND_ALLOC, 7'd0,   19'd0,       1'b1, STATUS_NO_SPACE, 19'd0},
        '{KIND_ALLOC, 7'd65,  19'h7FFFF,   1'b1, STATUS_NO_SPACE, 19'd0},
        '{KIND_ALLOC, 7'd127, 19'd0,       1'b1, STATUS_NO_SPACE, 19'd0},
        '{KIND_FREE,  7'd127, 19'd0,       1'b1, STATUS_NOT_HELD, 19'd0},
        '{KIND_FREE,  7'd0,   19'h7FFFF,   1'b1, STATUS_NOT_HELD, 19'd0},
        '{KIND_FREE,  7'd0,   19'd4095,    1'b1, STATUS_NOT_HELD, 19'd0},
        '{KIND_FREE,  7'd0,   19'd2048,    1'b1, STATUS_NOT_HELD, 19'd0},
        '{KIND_ALLOC, 7'd1,   19'd0,       1'b1, STATUS_OK,       19'd0},
        '{KIND_ALLOC, 7'd64,  19'd0,       1'b1, STATUS_OK,       19'd4096},
        '{KIND_FREE,  7'd0,   19'd0,       1'b1, STATUS_OK,       19'd0},
        '{KIND_FREE,  7'd0,   19'd0,       1'b1, STATUS_NOT_HELD, 19'd0},
        '{KIND_ALLOC, 7'd3,   19'd0,       1'b0, STATUS_OK,       19'd0},
        '{KIND_ALLOC, 7'd64,  19'd0,       1'b1, STATUS_NO_SPACE, 19'd0},
        '{KIND_ALLOC, 7'd61,  19'd0,       1'b0, STATUS_OK,       19'd0},
        '{KIND_ALLOC, 7'd1,   19'd0,       1'b1, STATUS_NO_SPACE, 19'd0},
        '{KIND_FREE,  7'd0,   19'd520192,  1'b1, STATUS_OK,       19'd0},
        '{KIND_ALLOC, 7'd1,   19'd0,       1'b1, STATUS_OK,       19'd520192},
        '{KIND_FREE,  7'd0,   19'd20480,   1'b0, STATUS_OK,       19'd0},
        '{KIND_FREE,  7'd0,   19'd40960,   1'b0, STATUS_OK,       19'd0},
        '{KIND_ALLOC, 7'd2,   19'd0,       1'b0, STATUS_OK,       19'd0},
        '{KIND_FREE,  7'd0,   19'd520192,  1'b0, STATUS_OK,       19'd0},
        '{KIND_FREE,  7'd0,   19'd520192,  1'b1, STATUS_NOT_HELD, 19'd0},
        '{KIND_ALLOC, 7'd64,  19'd0,       1'b0, STATUS_OK,       19'd0}
    };

    page_frame_free_list_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void model_request(input logic kind, input logic [COUNT_W-1:0] count,
                                          input logic [ADDR_W-1:0] addr, input bit record);
        grant_t g;
        int     frame;
        int     k;
        if (kind == KIND_ALLOC)
        begin
            if (count == 0 || count > MAX_REQUEST || count > avail)
            begin
                g = '{STATUS_NO_SPACE, '0, 1'b1};
                if (record)
                    pending_grants.push_back(g);
            end
            else
            begin
                for (k = 0; k < count; k++)
                begin
                    frame = head;
                    head = link_mem[frame];
                    held[frame] = 1'b1;
                    avail--;
                    g = '{STATUS_OK, ADDR_W'(frame * PAGE_BYTES), (k == count - 1)};
                    if (record)
                        pending_grants.push_back(g);
                end
            end
        end
        else
        begin
            frame = addr / PAGE_BYTES;
            if ((addr % PAGE_BYTES) != 0 || frame >= PAGES || !held[frame])
                g = '{STATUS_NOT_HELD, '0, 1'b1};
            else
            begin
                held[frame] = 1'b0;
                link_mem[frame] = head;
                head = 8'(frame);
                avail++;
                g = '{STATUS_OK, '0, 1'b1};
            end
            if (record)
                pending_grants.push_back(g);
        end
    endfunction

    function automatic stim_row_t pick_random_request();
        stim_row_t req;
        int        pick;
        int        cap;
        int        start;
        int        k;
        req = '0;
        req.count = COUNT_W'($urandom);
        req.addr = ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < ((avail > 64) ? 55 : 30))
        begin
            req.kind = KIND_ALLOC;
            if (avail == 0)
                req.count = 7'd1;
            else
            begin
                cap = ($urandom_range(0, 19) == 0) ? MAX_REQUEST : 4;
                if (cap > avail)
                    cap = avail;
                req.count = COUNT_W'($urandom_range(1, cap));
            end
        end
        else if (pick < 90 && avail < PAGES)
        begin
            req.kind = KIND_FREE;
            start = $urandom_range(0, PAGES - 1);
            for (k = 0; k < PAGES; k++)
            begin
                if (held[(start + k) % PAGES])
                begin
                    req.addr = ADDR_W'(((start + k) % PAGES) * PAGE_BYTES);
                    break;
                end
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    req.kind = KIND_ALLOC;
                    req.count = '0;
                end
                1:
                begin
                    req.kind = KIND_ALLOC;
                    req.count = COUNT_W'($urandom_range((avail < 64) ? avail + 1 : 65, 127));
                end
                2:
                begin
                    req.kind = KIND_FREE;
                    req.addr = {7'($urandom_range(0, 127)), 12'($urandom_range(1, 4095))};
                end
                default:
                begin
                    req.kind = KIND_FREE;
                    req.addr = ADDR_W'($urandom_range(0, PAGES - 1) * PAGE_BYTES);
                end
            endcase
        end
        return req;
    endfunction

    task automatic offer_request(input stim_row_t req);
        grant_t g;
        int     n;
        int     k;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, req.addr, req.count};
        s_axis_tuser  <= req.kind;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        model_request(req.kind, req.count, req.addr, !req.listed);
        if (req.listed)
        begin
            n = (req.kind == KIND_ALLOC && req.status == STATUS_OK) ? req.count : 1;
            for (k = 0; k < n; k++)
            begin
                g.status = req.status;
                g.address = (req.kind == KIND_ALLOC && req.status == STATUS_OK)
                            ? ADDR_W'(req.base + k * PAGE_BYTES) : '0;
                g.last = (k == n - 1);
                pending_grants.push_back(g);
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : grant_monitor
        grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: status %0d address %h last %0b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (m_axis_tuser !== OUT_USER_W'(want.status)
                    || m_axis_tdata !== OUT_DATA_W'(want.address)
                    || m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want status %0d addr %h last %0b, got %0d %h %0b",
                                 want.status, want.address, want.last,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < PAGES; i++)
        begin
            link_mem[i] = 8'(i + 1);
            held[i] = 1'b0;
        end
        head = '0;
        avail = PAGES;
        tx_idle_pct = 21;
        rx_idle_pct = 68;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            offer_request(directed_rows[i]);
        for (i = 0; i < 67; i++)
            offer_request(pick_random_request());

        tx_idle_pct = 68;
        rx_idle_pct = 21;
        for (i = 0; i < 67; i++)
            offer_request(pick_random_request());

        // stall the output long enough to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b1;
        for (i = 0; i < 66; i++)
            offer_request(pick_random_request());
        s_axis_tvalid <= 1'b0;

        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pffla_pkg.sv
rtl/pffla_ram.sv
rtl/page_frame_free_list_allocator.sv
rtl/pffla_checker.sv
tb/page_frame_free_list_allocator_test.sv
